### rtl/core/dvh_pkg.sv
// dvh_pkg: shared widths, codes and controller/datapath interface structs
// for the distinct vector histogram. No dependencies.
`default_nettype none

package dvh_pkg;

   // fixed field widths of the item and result channels
   localparam int DATA_W = 64;
   localparam int CNT_W  = 32;
   localparam int BIN_W  = 6;
   localparam int ELEM_W = 3;
   localparam int USED_W = 7;
   localparam int CFG_W  = 4;

   // request action codes
   localparam logic ACT_OBSERVE = 1'b0;
   localparam logic ACT_READ    = 1'b1;

   // result kind codes
   localparam logic KIND_UPDATE = 1'b0;
   localparam logic KIND_READ   = 1'b1;

   // commands from controller to datapath
   typedef struct packed {
      logic elem_store;
      logic scan_start;
      logic scan_run;
      logic hit_commit;
      logic miss_commit;
      logic rd_issue;
      logic rd_commit;
   } dvh_cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic vec_last;
      logic hit;
      logic scan_done;
   } dvh_sts_type;

endpackage

`default_nettype wire

### rtl/core/distinct_vector_histogram.sv
// distinct_vector_histogram: top level, joins controller and datapath.
// Depends on dvh_pkg, dvh_ctrl and dvh_datapath.
//
// Usage:
// - request channel: an item is taken at a rising edge with start high and
//   busy low; req_action selects an observation element or a bin read
// - an observation element that does not finish a vector is absorbed with
//   no result, and busy stays low
// - the element that finishes a vector starts a scan of the bin row memory,
//   one bin per cycle in bin order, with a two stage read/compare pipeline;
//   busy covers the scan, which ends early on a hit; the update result
//   shows once busy is low again, when the next item can already go in
// - a bin read costs one memory read, registered before the result register;
//   busy high for one cycle
// - result channel: rsp_valid marks each result for exactly one cycle; the
//   receiver takes it then and cannot stall the block
// - configuration: csr_data is the vector length, written when csr_valid
//   and csr_ready are high; csr_ready is low while busy; a write drops any
//   partially collected vector
// - reset: length returns to 1, the table empties (no bins in use) and any
//   partial vector is dropped; memory contents need no clearing pass

`default_nettype none

module distinct_vector_histogram #(
   parameter int MAX_BINS     = 64,
   parameter int MAX_ELEMENTS = 8
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // request channel
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic                          req_action,
   input  wire logic [dvh_pkg::DATA_W-1:0]    req_obs_value,
   input  wire logic [dvh_pkg::BIN_W-1:0]     req_read_bin,
   input  wire logic [dvh_pkg::ELEM_W-1:0]    req_read_element,
   // result channel
   output logic                               rsp_valid,
   output logic                               rsp_result_kind,
   output logic [dvh_pkg::BIN_W-1:0]          rsp_bin_index,
   output logic [dvh_pkg::CNT_W-1:0]          rsp_bin_count,
   output logic                               rsp_new_bin,
   output logic                               rsp_table_full,
   output logic [dvh_pkg::USED_W-1:0]         rsp_bins_used,
   output logic [dvh_pkg::DATA_W-1:0]         rsp_read_value,
   // configuration write channel
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [dvh_pkg::CFG_W-1:0]     csr_data
);
   import dvh_pkg::*;

   dvh_cmd_type cmd;
   dvh_sts_type sts;
   logic        cfg_write;

   // length register only changes while no item is in flight
   assign csr_ready = ~busy;
   assign cfg_write = csr_valid & csr_ready;

   // sequencer: idle, bin scan, bin read
   dvh_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_action (req_action),
      .sts        (sts),
      .busy       (busy),
      .cmd        (cmd)
   );

   // storage, scan pipeline and result registers
   dvh_datapath #(
      .MAX_BINS     (MAX_BINS),
      .MAX_ELEMENTS (MAX_ELEMENTS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .cfg_write        (cfg_write),
      .cfg_data         (csr_data),
      .req_obs_value    (req_obs_value),
      .req_read_bin     (req_read_bin),
      .req_read_element (req_read_element),
      .rsp_valid        (rsp_valid),
      .rsp_result_kind  (rsp_result_kind),
      .rsp_bin_index    (rsp_bin_index),
      .rsp_bin_count    (rsp_bin_count),
      .rsp_new_bin      (rsp_new_bin),
      .rsp_table_full   (rsp_table_full),
      .rsp_bins_used    (rsp_bins_used),
      .rsp_read_value   (rsp_read_value)
   );

endmodule

`default_nettype wire

### rtl/core/dvh_ctrl.sv
// dvh_ctrl: sequencing state machine of the distinct vector histogram.
// Depends on dvh_pkg for the command and status structs and action codes.
`default_nettype none

module dvh_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic               req_action,
   input  wire dvh_pkg::dvh_sts_type sts,
   output logic                    busy,
   output dvh_pkg::dvh_cmd_type    cmd
);
   import dvh_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_READ
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_action == ACT_OBSERVE) begin
                  cmd.elem_store = 1'b1;
                  cmd.scan_start = sts.vec_last;
                  state_in       = sts.vec_last ? ST_SCAN : ST_IDLE;
               end else begin
                  cmd.rd_issue = 1'b1;
                  state_in     = ST_READ;
               end
            end
         end
         ST_SCAN: begin
            cmd.scan_run = 1'b1;
            if (sts.hit) begin
               cmd.hit_commit = 1'b1;
               state_in       = ST_IDLE;
            end else if (sts.scan_done) begin
               cmd.miss_commit = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         ST_READ: begin
            cmd.rd_commit = 1'b1;
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         busy_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= (state_in != ST_IDLE);
      end
   end

   assign busy = busy_ff;

endmodule

`default_nettype wire

### rtl/core/dvh_datapath.sv
// dvh_datapath: pending vector, bin row and count memories, scan pipeline
// and result registers. Depends on dvh_pkg; driven by dvh_ctrl commands.
`default_nettype none

module dvh_datapath #(
   parameter int MAX_BINS     = 64,
   parameter int MAX_ELEMENTS = 8
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire dvh_pkg::dvh_cmd_type          cmd,
   output dvh_pkg::dvh_sts_type               sts,
   input  wire logic                          cfg_write,
   input  wire logic [dvh_pkg::CFG_W-1:0]     cfg_data,
   input  wire logic [dvh_pkg::DATA_W-1:0]    req_obs_value,
   input  wire logic [dvh_pkg::BIN_W-1:0]     req_read_bin,
   input  wire logic [dvh_pkg::ELEM_W-1:0]    req_read_element,
   output logic                               rsp_valid,
   output logic                               rsp_result_kind,
   output logic [dvh_pkg::BIN_W-1:0]          rsp_bin_index,
   output logic [dvh_pkg::CNT_W-1:0]          rsp_bin_count,
   output logic                               rsp_new_bin,
   output logic                               rsp_table_full,
   output logic [dvh_pkg::USED_W-1:0]         rsp_bins_used,
   output logic [dvh_pkg::DATA_W-1:0]         rsp_read_value
);
   import dvh_pkg::*;

   localparam int AW = $clog2(MAX_BINS);
   localparam int UW = $clog2(MAX_BINS + 1);
   localparam int PW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
   localparam int LW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS + 1) : 1;
   localparam logic [CNT_W-1:0] CNT_MAX = '1;

   typedef logic [MAX_ELEMENTS-1:0][DATA_W-1:0] row_type;

   // configuration and vector assembly
   logic [CFG_W-1:0]  cfg_len_ff, cfg_len_in;
   logic [PW-1:0]     pos_ff, pos_in;
   logic [DATA_W-1:0] pend_ff [MAX_ELEMENTS];
   logic [LW-1:0]     len;
   logic [PW-1:0]     wr_pos;
   logic              vec_last;
   row_type           pend_row;

   // table state
   logic [UW-1:0]     used_ff, used_in;
   logic              has_room;
   row_type           row_mem [MAX_BINS];
   logic [CNT_W-1:0]  cnt_mem [MAX_BINS];
   row_type           row_q_ff;
   logic [CNT_W-1:0]  cnt_q_ff;
   logic [AW-1:0]     rd_addr;

   // scan pipeline
   logic [UW-1:0]     scan_ptr_ff, scan_ptr_in;
   logic              issue;
   logic              s1_vld_ff, s1_vld_in;
   logic [AW-1:0]     s1_idx_ff, s1_idx_in;
   logic              eq;
   logic              hit_ff, hit_in;
   logic [AW-1:0]     hit_idx_ff, hit_idx_in;
   logic [CNT_W-1:0]  hit_cnt_ff, hit_cnt_in;
   logic [CNT_W-1:0]  cnt_sat;

   // count write port
   logic              cnt_we;
   logic [AW-1:0]     cnt_wa;
   logic [CNT_W-1:0]  cnt_wd;

   // read request
   logic [BIN_W-1:0]  rd_bin_ff;
   logic [ELEM_W-1:0] rd_elem_ff;
   logic              bin_ok;
   logic [DATA_W-1:0] elem_val;

   // result registers
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_kind_ff, rsp_kind_in;
   logic [BIN_W-1:0]  rsp_idx_ff, rsp_idx_in;
   logic [CNT_W-1:0]  rsp_cnt_ff, rsp_cnt_in;
   logic              rsp_new_ff, rsp_new_in;
   logic              rsp_full_ff, rsp_full_in;
   logic [USED_W-1:0] rsp_used_ff, rsp_used_in;
   logic [DATA_W-1:0] rsp_val_ff, rsp_val_in;

   // effective vector length, clamped to 1..MAX_ELEMENTS
   always_comb begin
      if (cfg_len_ff == '0) begin
         len = LW'(1);
      end else if (int'(cfg_len_ff) > MAX_ELEMENTS) begin
         len = LW'(MAX_ELEMENTS);
      end else begin
         len = LW'(cfg_len_ff);
      end
   end

   assign wr_pos   = (int'(pos_ff) >= int'(len)) ? '0 : pos_ff;
   assign vec_last = (int'(wr_pos) + 1 >= int'(len));

   always_comb begin
      for (int j = 0; j < MAX_ELEMENTS; j++) begin
         pend_row[j] = pend_ff[j];
      end
   end

   always_comb begin
      cfg_len_in = cfg_write ? cfg_data : cfg_len_ff;
      pos_in     = pos_ff;
      if (cfg_write) begin
         pos_in = '0;
      end else if (cmd.elem_store) begin
         pos_in = vec_last ? '0 : wr_pos + PW'(1);
      end
   end

   // scan issue and compare
   assign issue    = cmd.scan_run && (scan_ptr_ff < used_ff);
   assign rd_addr  = cmd.rd_issue ? AW'(req_read_bin) : AW'(scan_ptr_ff);
   assign has_room = (used_ff < UW'(MAX_BINS));
   assign cnt_sat  = (hit_cnt_ff == CNT_MAX) ? hit_cnt_ff : hit_cnt_ff + CNT_W'(1);

   always_comb begin
      eq = 1'b1;
      for (int j = 0; j < MAX_ELEMENTS; j++) begin
         if (j < int'(len) && row_q_ff[j] != pend_ff[j]) begin
            eq = 1'b0;
         end
      end
   end

   always_comb begin
      scan_ptr_in = scan_ptr_ff;
      s1_vld_in   = issue;
      s1_idx_in   = AW'(scan_ptr_ff);
      hit_in      = hit_ff;
      hit_idx_in  = hit_idx_ff;
      hit_cnt_in  = hit_cnt_ff;
      if (cmd.scan_start) begin
         scan_ptr_in = '0;
         s1_vld_in   = 1'b0;
         hit_in      = 1'b0;
      end else begin
         if (issue) begin
            scan_ptr_in = scan_ptr_ff + UW'(1);
         end
         if (cmd.scan_run) begin
            hit_in     = s1_vld_ff & eq;
            hit_idx_in = s1_idx_ff;
            hit_cnt_in = cnt_q_ff;
         end
      end
   end

   assign sts.vec_last  = vec_last;
   assign sts.hit       = hit_ff;
   assign sts.scan_done = (scan_ptr_ff >= used_ff) & ~s1_vld_ff & ~hit_ff;

   // table updates
   always_comb begin
      used_in = used_ff;
      if (cmd.miss_commit && has_room) begin
         used_in = used_ff + UW'(1);
      end
   end

   assign cnt_we = cmd.hit_commit | (cmd.miss_commit & has_room);
   assign cnt_wa = cmd.hit_commit ? hit_idx_ff : AW'(used_ff);
   assign cnt_wd = cmd.hit_commit ? cnt_sat : CNT_W'(1);

   // read data selection
   assign bin_ok = (int'(rd_bin_ff) < int'(used_ff)) && (int'(rd_bin_ff) < MAX_BINS);

   always_comb begin
      elem_val = '0;
      for (int j = 0; j < MAX_ELEMENTS; j++) begin
         if (int'(rd_elem_ff) == j) begin
            elem_val = row_q_ff[j];
         end
      end
   end

   // result formatting
   always_comb begin
      rsp_valid_in = cmd.hit_commit | cmd.miss_commit | cmd.rd_commit;
      rsp_kind_in  = KIND_UPDATE;
      rsp_idx_in   = '0;
      rsp_cnt_in   = '0;
      rsp_new_in   = 1'b0;
      rsp_full_in  = 1'b0;
      rsp_used_in  = USED_W'(used_ff);
      rsp_val_in   = '0;
      if (cmd.hit_commit) begin
         rsp_idx_in = BIN_W'(hit_idx_ff);
         rsp_cnt_in = cnt_sat;
      end else if (cmd.miss_commit) begin
         if (has_room) begin
            rsp_idx_in  = BIN_W'(used_ff);
            rsp_cnt_in  = CNT_W'(1);
            rsp_new_in  = 1'b1;
            rsp_used_in = USED_W'(used_ff + UW'(1));
         end else begin
            rsp_full_in = 1'b1;
         end
      end else if (cmd.rd_commit) begin
         rsp_kind_in = KIND_READ;
         rsp_idx_in  = rd_bin_ff;
         if (bin_ok) begin
            rsp_cnt_in = cnt_q_ff;
            if (int'(rd_elem_ff) < int'(len)) begin
               rsp_val_in = elem_val;
            end
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_len_ff   <= CFG_W'(1);
         pos_ff       <= '0;
         used_ff      <= '0;
         scan_ptr_ff  <= '0;
         s1_vld_ff    <= 1'b0;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_len_ff   <= cfg_len_in;
         pos_ff       <= pos_in;
         used_ff      <= used_in;
         scan_ptr_ff  <= scan_ptr_in;
         s1_vld_ff    <= s1_vld_in;
         hit_ff       <= hit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      s1_idx_ff  <= s1_idx_in;
      hit_idx_ff <= hit_idx_in;
      hit_cnt_ff <= hit_cnt_in;
      if (cmd.elem_store) begin
         pend_ff[wr_pos] <= req_obs_value;
      end
      if (cmd.rd_issue) begin
         rd_bin_ff  <= req_read_bin;
         rd_elem_ff <= req_read_element;
      end
      if (rsp_valid_in) begin
         rsp_kind_ff <= rsp_kind_in;
         rsp_idx_ff  <= rsp_idx_in;
         rsp_cnt_ff  <= rsp_cnt_in;
         rsp_new_ff  <= rsp_new_in;
         rsp_full_ff <= rsp_full_in;
         rsp_used_ff <= rsp_used_in;
         rsp_val_ff  <= rsp_val_in;
      end
   end

   // bin row memory: one row per bin, written on creation
   always_ff @(posedge clock) begin
      if (cmd.miss_commit && has_room) begin
         row_mem[AW'(used_ff)] <= pend_row;
      end
      row_q_ff <= row_mem[rd_addr];
   end

   // bin count memory
   always_ff @(posedge clock) begin
      if (cnt_we) begin
         cnt_mem[cnt_wa] <= cnt_wd;
      end
      cnt_q_ff <= cnt_mem[rd_addr];
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_kind = rsp_kind_ff;
   assign rsp_bin_index   = rsp_idx_ff;
   assign rsp_bin_count   = rsp_cnt_ff;
   assign rsp_new_bin     = rsp_new_ff;
   assign rsp_table_full  = rsp_full_ff;
   assign rsp_bins_used   = rsp_used_ff;
   assign rsp_read_value  = rsp_val_ff;

endmodule

`default_nettype wire

### tb/sv/testbench.sv
// testbench: self-checking bench for distinct_vector_histogram, with an
// in-bench histogram model, random vectors and reads, and length changes.
// Depends on dvh_pkg and the distinct_vector_histogram RTL.

module testbench;
   import dvh_pkg::*;

   localparam int MAX_BINS      = 64;
   localparam int MAX_ELEMS     = 8;
   localparam int N_PHASES      = 8;
   localparam int PHASE_ITEMS   = 215;
   // worst scan of a full table plus pipeline slack
   localparam int SETTLE_CYCLES = MAX_BINS + 8;

   // one result as the block presents it
   typedef struct packed {
      logic              kind;
      logic [BIN_W-1:0]  bin_idx;
      logic [CNT_W-1:0]  count;
      logic              created;
      logic              full;
      logic [USED_W-1:0] used;
      logic [DATA_W-1:0] value;
   } hist_result_type;

   // histogram model plus the queue of results still due from the block
   class hist_scoreboard;
      logic [CFG_W-1:0]  length_reg;
      logic [DATA_W-1:0] partial_vec [MAX_ELEMS];
      int unsigned       position;
      logic [DATA_W-1:0] bin_vals [MAX_BINS][MAX_ELEMS];
      logic [CNT_W-1:0]  bin_cnts [MAX_BINS];
      int unsigned       used;
      hist_result_type   due_results [$];
      int unsigned       errors;

      function new();
         length_reg = CFG_W'(1);
         position   = 0;
         used       = 0;
         errors     = 0;
         foreach (partial_vec[j]) partial_vec[j] = '0;
         foreach (bin_vals[b, j]) bin_vals[b][j] = '0;
         foreach (bin_cnts[b]) bin_cnts[b] = '0;
      endfunction

      // zero acts as one, anything past the table width is clipped
      function int unsigned vector_length();
         if (length_reg == 0) return 1;
         if (length_reg > MAX_ELEMS) return MAX_ELEMS;
         return length_reg;
      endfunction

      function void set_length(logic [CFG_W-1:0] v);
         length_reg = v;
         position   = 0;
      endfunction

      function void take_item(logic action, logic [DATA_W-1:0] obs,
                              logic [BIN_W-1:0] rbin, logic [ELEM_W-1:0] relem);
         hist_result_type r;
         int unsigned     len;
         int              found;
         int              b;
         int              j;
         logic            same;
         len = vector_length();
         r   = '0;
         if (action == ACT_OBSERVE) begin
            if (position >= len) position = 0;
            partial_vec[position] = obs;
            position++;
            if (position < len) return;
            position = 0;
            found = -1;
            for (b = 0; b < used; b++) begin
               if (found < 0) begin
                  same = 1'b1;
                  for (j = 0; j < len; j++)
                     if (bin_vals[b][j] !== partial_vec[j]) same = 1'b0;
                  if (same) found = b;
               end
            end
            r.kind = KIND_UPDATE;
            if (found >= 0) begin
               if (bin_cnts[found] != '1) bin_cnts[found]++;
               r.bin_idx = BIN_W'(found);
               r.count   = bin_cnts[found];
            end else if (used < MAX_BINS) begin
               for (j = 0; j < len; j++) bin_vals[used][j] = partial_vec[j];
               bin_cnts[used] = CNT_W'(1);
               r.bin_idx = BIN_W'(used);
               r.count   = CNT_W'(1);
               r.created = 1'b1;
               used++;
            end else begin
               r.full = 1'b1;
            end
         end else begin
            r.kind    = KIND_READ;
            r.bin_idx = rbin;
            if (rbin < used) begin
               r.count = bin_cnts[rbin];
               if (relem < len) r.value = bin_vals[rbin][relem];
            end
         end
         r.used = USED_W'(used);
         due_results.push_back(r);
      endfunction

      task report_mismatch(string msg);
         errors++;
         $display("mismatch: %s", msg);
      endtask

      task check_result(hist_result_type got);
         hist_result_type want;
         if (due_results.size() == 0) begin
            report_mismatch($sformatf("result with nothing due, kind %0d bin %0d",
                                      got.kind, got.bin_idx));
            return;
         end
         want = due_results.pop_front();
         if (got.kind !== want.kind)
            report_mismatch($sformatf("result_kind %0d, want %0d", got.kind, want.kind));
         if (got.bin_idx !== want.bin_idx)
            report_mismatch($sformatf("bin_index %0d, want %0d", got.bin_idx, want.bin_idx));
         if (got.count !== want.count)
            report_mismatch($sformatf("bin_count %0d, want %0d", got.count, want.count));
         if (got.created !== want.created)
            report_mismatch($sformatf("new_bin %0d, want %0d", got.created, want.created));
         if (got.full !== want.full)
            report_mismatch($sformatf("table_full %0d, want %0d", got.full, want.full));
         if (got.used !== want.used)
            report_mismatch($sformatf("bins_used %0d, want %0d", got.used, want.used));
         if (got.value !== want.value)
            report_mismatch($sformatf("read_value %h, want %h", got.value, want.value));
      endtask
   endclass

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   logic                req_action;
   logic [DATA_W-1:0]   req_obs_value;
   logic [BIN_W-1:0]    req_read_bin;
   logic [ELEM_W-1:0]   req_read_element;
   logic                rsp_valid;
   logic                rsp_result_kind;
   logic [BIN_W-1:0]    rsp_bin_index;
   logic [CNT_W-1:0]    rsp_bin_count;
   logic                rsp_new_bin;
   logic                rsp_table_full;
   logic [USED_W-1:0]   rsp_bins_used;
   logic [DATA_W-1:0]   rsp_read_value;
   logic                csr_valid;
   logic                csr_ready;
   logic [CFG_W-1:0]    csr_data;

   hist_scoreboard      sb;
   int unsigned         sent_items;
   bit                  gaps_enabled;
   // lengths never grow once bins exist, so no bin is compared or read
   // past the elements it was created with
   logic [CFG_W-1:0]    phase_lengths [N_PHASES] = '{15, 12, 8, 6, 3, 2, 1, 0};

   distinct_vector_histogram #(
      .MAX_BINS     (MAX_BINS),
      .MAX_ELEMENTS (MAX_ELEMS)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_action       (req_action),
      .req_obs_value    (req_obs_value),
      .req_read_bin     (req_read_bin),
      .req_read_element (req_read_element),
      .rsp_valid        (rsp_valid),
      .rsp_result_kind  (rsp_result_kind),
      .rsp_bin_index    (rsp_bin_index),
      .rsp_bin_count    (rsp_bin_count),
      .rsp_new_bin      (rsp_new_bin),
      .rsp_table_full   (rsp_table_full),
      .rsp_bins_used    (rsp_bins_used),
      .rsp_read_value   (rsp_read_value),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_data         (csr_data)
   );

   // 12 unit clock period
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // hard stop, several times the slowest legal run
   initial begin
      #(12 * 1000000);
      $display("Regression FAIL");
      $finish;
   end

   // results cannot be held off, so every strobe is taken on its edge
   always @(posedge clock) begin : rsp_monitor
      hist_result_type got;
      if (!reset && rsp_valid) begin
         got.kind    = rsp_result_kind;
         got.bin_idx = rsp_bin_index;
         got.count   = rsp_bin_count;
         got.created = rsp_new_bin;
         got.full    = rsp_table_full;
         got.used    = rsp_bins_used;
         got.value   = rsp_read_value;
         sb.check_result(got);
      end
   end

   // one item on the request channel; start stays high on return so a
   // following item goes out back to back
   task automatic send_item(logic action, logic [DATA_W-1:0] obs,
                            logic [BIN_W-1:0] rbin, logic [ELEM_W-1:0] relem);
      if (gaps_enabled && $urandom_range(3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(5, 1)) @(posedge clock);
      end
      start            <= 1'b1;
      req_action       <= action;
      req_obs_value    <= obs;
      req_read_bin     <= rbin;
      req_read_element <= relem;
      do @(posedge clock); while (busy);
      sb.take_item(action, obs, rbin, relem);
      sent_items++;
   endtask

   // bin read; the unused observation field still gets random bits
   task automatic send_read(logic [BIN_W-1:0] rbin, logic [ELEM_W-1:0] relem);
      send_item(ACT_READ, {$urandom, $urandom}, rbin, relem);
   endtask

   // first count elements of a vector, one observation item each
   task automatic send_vector(logic [DATA_W-1:0] vec [MAX_ELEMS], int unsigned count);
      int unsigned j;
      for (j = 0; j < count; j++)
         send_item(ACT_OBSERVE, vec[j], BIN_W'($urandom), ELEM_W'($urandom));
   endtask

   // mostly full random, with a share of all-zero, all-one and tiny values
   function automatic logic [DATA_W-1:0] random_element();
      case ($urandom_range(7))
         0:       return '0;
         1:       return '1;
         2:       return DATA_W'($urandom_range(3));
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // length write only once the block is quiet; a partial vector gives no
   // result, so allow a full scan time after the last one
   task automatic write_length(logic [CFG_W-1:0] v);
      start <= 1'b0;
      while (sb.due_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= v;
      do @(posedge clock); while (!csr_ready);
      sb.set_length(v);
      csr_valid <= 1'b0;
   endtask

   initial begin : stimulus
      logic [DATA_W-1:0] vec [MAX_ELEMS];
      int unsigned       p;
      int unsigned       j;
      int unsigned       len;
      int unsigned       pick;
      int unsigned       phase_end;

      sb           = new();
      sent_items   = 0;
      gaps_enabled = 1'b1;
      reset            <= 1'b1;
      start            <= 1'b0;
      req_action       <= ACT_OBSERVE;
      req_obs_value    <= '0;
      req_read_bin     <= '0;
      req_read_element <= '0;
      csr_valid        <= 1'b0;
      csr_data         <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // empty table reads back zero, lowest and highest bin
      send_read(BIN_W'(0), ELEM_W'(0));
      send_read('1, '1);

      // longest vectors: a new bin, then the same vector again as a hit
      write_length(phase_lengths[0]);
      vec[0] = '1;
      vec[1] = '0;
      vec[2] = {(DATA_W/2){2'b10}};
      vec[3] = {(DATA_W/2){2'b01}};
      vec[4] = DATA_W'(1);
      vec[5] = {1'b1, {(DATA_W-1){1'b0}}};
      vec[6] = 64'h0123_4567_89ab_cdef;
      vec[7] = 64'hfedc_ba98_7654_3210;
      send_vector(vec, MAX_ELEMS);
      send_vector(vec, MAX_ELEMS);
      send_read(BIN_W'(0), '1);
      send_read(BIN_W'(0), ELEM_W'(0));
      send_read('1, '1);

      // random phases, lengths stepping down to zero
      for (p = 0; p < N_PHASES; p++) begin
         if (p != 0) write_length(phase_lengths[p]);
         len          = sb.vector_length();
         phase_end    = sent_items + PHASE_ITEMS;
         gaps_enabled = (p != N_PHASES - 1);
         while (sent_items < phase_end) begin
            // toggle between gappy and back-to-back stretches
            if (p != N_PHASES - 1 && $urandom_range(39) == 0)
               gaps_enabled = !gaps_enabled;
            if ($urandom_range(4) == 0) begin
               // reads lean toward bins that hold data
               if (sb.used != 0 && $urandom_range(2) != 0)
                  send_read(BIN_W'($urandom_range(sb.used - 1)), ELEM_W'($urandom));
               else
                  send_read(BIN_W'($urandom), ELEM_W'($urandom));
            end else begin
               // half the vectors repeat a stored bin to get hits
               if (sb.used != 0 && $urandom_range(1) == 0) begin
                  pick = $urandom_range(sb.used - 1);
                  for (j = 0; j < MAX_ELEMS; j++) vec[j] = sb.bin_vals[pick][j];
               end else begin
                  for (j = 0; j < MAX_ELEMS; j++) vec[j] = random_element();
               end
               send_vector(vec, len);
            end
         end
         // sometimes leave a partial vector for the length write to drop
         if (len > 1 && $urandom_range(1) == 0) begin
            for (j = 0; j < MAX_ELEMS; j++) vec[j] = random_element();
            send_vector(vec, $urandom_range(len - 1, 1));
         end
      end

      // drain, then allow for a last scan before the verdict
      start <= 1'b0;
      while (sb.due_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.due_results.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

### sim.f
rtl/core/dvh_pkg.sv
rtl/core/dvh_ctrl.sv
rtl/core/dvh_datapath.sv
rtl/core/distinct_vector_histogram.sv
tb/sv/testbench.sv
